// ===== hw/rtl/dht_pkg.sv =====
// ----------------------------------------------------------------------------
// dht_pkg
// Shared types, codes and the sequencer control store of the double hash table.
// ----------------------------------------------------------------------------
package dht_pkg;

    // field widths
    localparam int KIND_W    = 2;
    localparam int KEY_W     = 31;
    localparam int OUTCOME_W = 3;
    localparam int SLOT_W    = 7;
    localparam int STATUS_W  = 2;

    // default table size
    localparam int TABLE_SIZE_DEF = 127;

    typedef logic [KIND_W-1:0]    kind_t;
    typedef logic [KEY_W-1:0]     key_t;
    typedef logic [OUTCOME_W-1:0] outcome_t;
    typedef logic [SLOT_W-1:0]    slot_t;
    typedef logic [STATUS_W-1:0]  status_t;

    // operation codes
    localparam kind_t KIND_INSERT = 2'd0;
    localparam kind_t KIND_DELETE = 2'd1;
    localparam kind_t KIND_SEARCH = 2'd2;
    localparam kind_t KIND_NONE   = 2'd3;

    // result codes
    localparam outcome_t OUT_INSERTED  = 3'd0;
    localparam outcome_t OUT_FULL      = 3'd1;
    localparam outcome_t OUT_DELETED   = 3'd2;
    localparam outcome_t OUT_FOUND     = 3'd3;
    localparam outcome_t OUT_NOT_FOUND = 3'd4;

    // entry status codes
    localparam status_t ST_EMPTY   = 2'd0;
    localparam status_t ST_USED    = 2'd1;
    localparam status_t ST_DELETED = 2'd2;

    // sequencer step addresses
    typedef logic [2:0] step_t;
    localparam step_t S_CLEAR    = 3'd0;
    localparam step_t S_IDLE     = 3'd1;
    localparam step_t S_MOD      = 3'd2;
    localparam step_t S_DISPATCH = 3'd3;
    localparam step_t S_READ     = 3'd4;
    localparam step_t S_EVAL     = 3'd5;
    localparam step_t S_POST     = 3'd6;

    // branch conditions
    typedef logic [2:0] cond_t;
    localparam cond_t C_ALWAYS   = 3'd0;
    localparam cond_t C_ACCEPT   = 3'd1;
    localparam cond_t C_LAST_POS = 3'd2;
    localparam cond_t C_NO_OP    = 3'd3;
    localparam cond_t C_STOP     = 3'd4;
    localparam cond_t C_OUT_FREE = 3'd5;

    // one control word per step
    typedef struct packed {
        logic  ready;     // take a request word
        logic  clr_wr;    // write an empty entry, advance position
        logic  mod_mul;   // key times reciprocal of table size
        logic  mod_rem;   // correct the remainder, set the home position
        logic  rd_en;     // read entry at current position
        logic  eval;      // judge the entry just read
        logic  post;      // hand result to the output register
        cond_t cond;
        step_t t_true;
        step_t t_false;
    } ctrl_word_t;

    // control store
    function automatic ctrl_word_t ucode(input step_t step);
        ctrl_word_t cw;
        cw = '0;
        cw.t_true  = S_IDLE;
        cw.t_false = S_IDLE;
        case (step)
            S_CLEAR:
            begin
                cw.clr_wr  = 1'b1;
                cw.cond    = C_LAST_POS;
                cw.t_true  = S_IDLE;
                cw.t_false = S_CLEAR;
            end
            S_IDLE:
            begin
                cw.ready   = 1'b1;
                cw.cond    = C_ACCEPT;
                cw.t_true  = S_MOD;
                cw.t_false = S_IDLE;
            end
            S_MOD:
            begin
                cw.mod_mul = 1'b1;
                cw.cond    = C_ALWAYS;
                cw.t_true  = S_DISPATCH;
                cw.t_false = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                cw.mod_rem = 1'b1;
                cw.cond    = C_NO_OP;
                cw.t_true  = S_POST;
                cw.t_false = S_READ;
            end
            S_READ:
            begin
                cw.rd_en   = 1'b1;
                cw.cond    = C_ALWAYS;
                cw.t_true  = S_EVAL;
                cw.t_false = S_EVAL;
            end
            S_EVAL:
            begin
                cw.eval    = 1'b1;
                cw.cond    = C_STOP;
                cw.t_true  = S_POST;
                cw.t_false = S_READ;
            end
            S_POST:
            begin
                cw.post    = 1'b1;
                cw.cond    = C_OUT_FREE;
                cw.t_true  = S_IDLE;
                cw.t_false = S_POST;
            end
            default:
            begin
                cw = '0;
                cw.t_true  = S_IDLE;
                cw.t_false = S_IDLE;
            end
        endcase
        return cw;
    endfunction

endpackage

// ===== hw/rtl/dht_in_if.sv =====
// ----------------------------------------------------------------------------
// dht_in_if
// Request channel: operation kind and key, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dht_in_if;
    import dht_pkg::*;

    logic  valid;
    logic  ready;
    kind_t kind;
    key_t  key;

    modport source (output valid, output kind, output key, input ready);
    modport sink   (input valid, input kind, input key, output ready);
endinterface

// ===== hw/rtl/dht_out_if.sv =====
// ----------------------------------------------------------------------------
// dht_out_if
// Response channel: outcome and slot, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dht_out_if;
    import dht_pkg::*;

    logic     valid;
    logic     ready;
    outcome_t outcome;
    slot_t    slot;

    modport source (output valid, output outcome, output slot, input ready);
    modport sink   (input valid, input outcome, input slot, output ready);
endinterface

// ===== hw/rtl/double_hash_table_top.sv =====
// ----------------------------------------------------------------------------
// double_hash_table_top
// Open-addressing hash table with double hashing, run by a small microcoded
// sequencer over one entry RAM holding status and key per slot.
// ----------------------------------------------------------------------------
//  channel | dir | fields          | meaning
//  --------+-----+-----------------+---------------------------------------
//  req     | in  | kind, key       | insert / delete / search request word
//  rsp     | out | outcome, slot   | one result word per request word
//
//  After reset a clearing pass writes every entry empty, with req.ready low
//  until it ends.
//  A request walks idle, key mod, dispatch, P probes (1..TABLE_SIZE) and
//  post; an unused kind skips the probes.
//  Key mod TABLE_SIZE takes two steps, a reciprocal multiply and a remainder
//  correction; each probe costs a RAM read plus one evaluate step because
//  the RAM read is registered.
//  The result sits in an output register; a stalled rsp holds the sequencer
//  in its post step only once a second result is ready.
// ----------------------------------------------------------------------------
module double_hash_table_top #(
    parameter int TABLE_SIZE = dht_pkg::TABLE_SIZE_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    dht_in_if.sink    req,
    dht_out_if.source rsp
);
    import dht_pkg::*;

    localparam int PW     = $clog2(TABLE_SIZE);
    localparam int RAM_W  = STATUS_W + KEY_W;
    localparam int PROD_W = KEY_W + 32;

    // floor(2^KEY_W / TABLE_SIZE), quotient estimate is low by at most one
    localparam logic [31:0] MOD_RECIP = 32'((64'd1 << KEY_W) / 64'(TABLE_SIZE));

    // sequencer
    step_t      step_reg, step_next;
    ctrl_word_t uc;
    logic       cond_hit;

    // datapath registers
    logic [PW-1:0]    pos_reg, pos_next;
    logic [PW-1:0]    n_reg, n_next;
    logic [PW:0]      quot_lo_reg, quot_lo_next;
    kind_t            kind_reg, kind_next;
    key_t             key_reg, key_next;
    outcome_t         outcome_reg, outcome_next;
    logic [PW-1:0]    slot_reg, slot_next;

    // output register
    logic     rsp_valid_reg, rsp_valid_next;
    outcome_t rsp_outcome_reg, rsp_outcome_next;
    slot_t    rsp_slot_reg, rsp_slot_next;

    // combinational helpers
    logic                accept;
    logic                out_free;
    logic [PROD_W-1:0]   mod_prod;
    logic [PW:0]         rem_raw;
    logic [PW-1:0]       mod_pos;
    logic [3:0]          probe_step;
    logic [PW:0]         probe_sum;
    logic [PW-1:0]       probe_pos;
    logic                last_pos;
    logic                lap_end;
    logic [RAM_W-1:0]    rd_data;
    status_t             rd_status;
    key_t                rd_key;
    logic                is_insert;
    logic                ins_hit;
    logic                look_empty;
    logic                look_hit;
    logic                stop;
    logic                ram_we;
    status_t             wr_status;
    logic [RAM_W-1:0]    wr_data;
    logic [PW+SLOT_W-1:0] slot_ext;

    assign uc       = ucode(step_reg);
    assign accept   = uc.ready && req.valid;
    assign out_free = !rsp_valid_reg || rsp.ready;

    // key mod table size: quotient estimate, then remainder with one correction
    assign mod_prod = PROD_W'(key_reg) * PROD_W'(MOD_RECIP);
    assign rem_raw  = key_reg[PW:0] - quot_lo_reg * (PW+1)'(TABLE_SIZE);
    assign mod_pos  = (rem_raw >= (PW+1)'(TABLE_SIZE))
                      ? PW'(rem_raw - (PW+1)'(TABLE_SIZE)) : PW'(rem_raw);

    // next position on the probe path
    assign probe_step = 4'd8 - {1'b0, key_reg[2:0]};
    assign probe_sum  = {1'b0, pos_reg} + (PW+1)'(probe_step);
    assign probe_pos  = (probe_sum >= (PW+1)'(TABLE_SIZE))
                        ? PW'(probe_sum - (PW+1)'(TABLE_SIZE)) : PW'(probe_sum);

    assign last_pos = (pos_reg == PW'(TABLE_SIZE - 1));
    assign lap_end  = (n_reg == PW'(TABLE_SIZE - 1));

    // entry judgement
    assign rd_status  = rd_data[KEY_W +: STATUS_W];
    assign rd_key     = rd_data[KEY_W-1:0];
    assign is_insert  = (kind_reg == KIND_INSERT);
    assign ins_hit    = is_insert && (rd_status != ST_USED);
    assign look_empty = !is_insert && (rd_status == ST_EMPTY);
    assign look_hit   = !is_insert && (rd_status == ST_USED) && (rd_key == key_reg);
    assign stop       = ins_hit || look_empty || look_hit || lap_end;

    // branch condition select
    always_comb
    begin
        case (uc.cond)
            C_ALWAYS:   cond_hit = 1'b1;
            C_ACCEPT:   cond_hit = req.valid;
            C_LAST_POS: cond_hit = last_pos;
            C_NO_OP:    cond_hit = (kind_reg == KIND_NONE);
            C_STOP:     cond_hit = stop;
            C_OUT_FREE: cond_hit = out_free;
            default:    cond_hit = 1'b0;
        endcase
    end

    assign step_next = cond_hit ? uc.t_true : uc.t_false;

    // datapath next values
    always_comb
    begin
        pos_next     = pos_reg;
        n_next       = n_reg;
        quot_lo_next = quot_lo_reg;
        kind_next    = kind_reg;
        key_next     = key_reg;
        outcome_next = outcome_reg;
        slot_next    = slot_reg;

        if (uc.clr_wr)
        begin
            pos_next = last_pos ? pos_reg : pos_reg + PW'(1);
        end

        if (accept)
        begin
            kind_next    = req.kind;
            key_next     = req.key;
            pos_next     = '0;
            n_next       = '0;
            outcome_next = (req.kind == KIND_INSERT) ? OUT_FULL : OUT_NOT_FOUND;
            slot_next    = '0;
        end

        if (uc.mod_mul)
        begin
            quot_lo_next = mod_prod[KEY_W +: PW+1];
        end

        if (uc.mod_rem)
        begin
            pos_next = mod_pos;
        end

        if (uc.eval)
        begin
            if (ins_hit)
            begin
                outcome_next = OUT_INSERTED;
                slot_next    = pos_reg;
            end
            else if (look_hit)
            begin
                outcome_next = (kind_reg == KIND_DELETE) ? OUT_DELETED : OUT_FOUND;
                slot_next    = pos_reg;
            end
            else if (!stop)
            begin
                pos_next = probe_pos;
                n_next   = n_reg + PW'(1);
            end
        end
    end

    // entry RAM write
    assign ram_we    = uc.clr_wr
                       || (uc.eval && (ins_hit || (look_hit && (kind_reg == KIND_DELETE))));
    assign wr_status = uc.clr_wr ? ST_EMPTY : (is_insert ? ST_USED : ST_DELETED);
    assign wr_data   = {wr_status, uc.clr_wr ? key_t'(0) : key_reg};

    dht_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TABLE_SIZE)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg),
        .wdata (wr_data),
        .re    (uc.rd_en),
        .raddr (pos_reg),
        .rdata (rd_data)
    );

    // output register
    assign slot_ext = {{SLOT_W{1'b0}}, slot_reg};

    always_comb
    begin
        rsp_valid_next   = rsp_valid_reg;
        rsp_outcome_next = rsp_outcome_reg;
        rsp_slot_next    = rsp_slot_reg;
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (uc.post && out_free)
        begin
            rsp_valid_next   = 1'b1;
            rsp_outcome_next = outcome_reg;
            rsp_slot_next    = slot_ext[SLOT_W-1:0];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= S_CLEAR;
            pos_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            pos_reg       <= pos_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        n_reg           <= n_next;
        quot_lo_reg     <= quot_lo_next;
        kind_reg        <= kind_next;
        key_reg         <= key_next;
        outcome_reg     <= outcome_next;
        slot_reg        <= slot_next;
        rsp_outcome_reg <= rsp_outcome_next;
        rsp_slot_reg    <= rsp_slot_next;
    end

    assign req.ready   = uc.ready;
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.outcome = rsp_outcome_reg;
    assign rsp.slot    = rsp_slot_reg;

endmodule

// ===== hw/rtl/dht_ram.sv =====
// ----------------------------------------------------------------------------
// dht_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/dht_checker.sv =====
// ----------------------------------------------------------------------------
// dht_checker
// Port-level assertions for the double hash table, bound to the top level.
// ----------------------------------------------------------------------------
module dht_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input dht_pkg::outcome_t rsp_outcome,
    input dht_pkg::slot_t    rsp_slot
);
    import dht_pkg::*;

    // stalled response word stays
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // stalled response word does not change
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_outcome) && $stable(rsp_slot))
        else $error("response changed while stalled");

    // only defined outcome codes leave the block
    a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_outcome == OUT_INSERTED || rsp_outcome == OUT_FULL
                       || rsp_outcome == OUT_DELETED || rsp_outcome == OUT_FOUND
                       || rsp_outcome == OUT_NOT_FOUND))
        else $error("undefined outcome code");

    // misses report slot zero
    a_miss_slot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_outcome == OUT_FULL || rsp_outcome == OUT_NOT_FOUND)
        |-> rsp_slot == '0)
        else $error("miss with nonzero slot");

    // one request word in flight at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

endmodule

bind double_hash_table_top dht_checker u_dht_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_outcome (rsp.outcome),
    .rsp_slot    (rsp.slot)
);
